[src/cfc_pkg.sv]
package cfc_pkg;

  localparam int unsigned IdW      = 29;
  localparam int unsigned LenW     = 4;
  localparam int unsigned BytesW   = 64;
  localparam int unsigned StampW   = 32;
  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 136;

  localparam logic CMD_STORE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE,
    ST_EMIT
  } cfc_state_e;

  // One table slot as kept in the RAM.
  typedef struct packed {
    logic [StampW-1:0] stamp;
    logic [BytesW-1:0] bytes;
    logic              gen;
    logic [LenW-1:0]   len;
    logic              rtr;
    logic              ext;
    logic [IdW-1:0]    id;
  } cfc_entry_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic write;
    logic emit;
  } cfc_cmd_t;

  typedef struct packed {
    logic is_store;
    logic out_full;
  } cfc_stat_t;

  // Mask covering the first min(len,8) bytes.
  function automatic logic [BytesW-1:0] byte_mask(input logic [LenW-1:0] len);
    logic [BytesW-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (len > LenW'(b)) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

[src/cfc_ram.sv]
module cfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/cfc_ctrl.sv]
module cfc_ctrl #(
  parameter int unsigned ENTRIES = 96
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  cfc_pkg::cfc_stat_t         stat_i,
  output cfc_pkg::cfc_cmd_t          cmd_o,
  output logic [$clog2(ENTRIES)-1:0] rd_addr_o
);

  localparam int unsigned AddrW = $clog2(ENTRIES);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(ENTRIES - 1);

  cfc_pkg::cfc_state_e state_q, state_d;
  logic [AddrW-1:0]    addr_q, addr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfc_pkg::ST_IDLE;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    case (state_q)
      cfc_pkg::ST_IDLE: begin
        addr_d = '0;
        if (in_valid_i) begin
          state_d = cfc_pkg::ST_SCAN;
        end
      end
      cfc_pkg::ST_SCAN: begin
        addr_d = addr_q + AddrW'(1);
        if (addr_q == LastAddr) begin
          state_d = cfc_pkg::ST_DRAIN;
        end
      end
      cfc_pkg::ST_DRAIN: begin
        state_d = stat_i.is_store ? cfc_pkg::ST_WRITE : cfc_pkg::ST_EMIT;
      end
      cfc_pkg::ST_WRITE: begin
        state_d = cfc_pkg::ST_IDLE;
      end
      cfc_pkg::ST_EMIT: begin
        if (!stat_i.out_full) begin
          state_d = cfc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cfc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    rd_addr_o   = addr_q;
    case (state_q)
      cfc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      cfc_pkg::ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
      end
      cfc_pkg::ST_DRAIN: begin
      end
      cfc_pkg::ST_WRITE: begin
        cmd_o.write = 1'b1;
      end
      cfc_pkg::ST_EMIT: begin
        cmd_o.emit = !stat_i.out_full;
      end
      default: begin
      end
    endcase
  end

endmodule

[src/cfc_dp.sv]
module cfc_dp #(
  parameter int unsigned ENTRIES = 96
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cfc_pkg::cfc_cmd_t                    cmd_i,
  input  logic [$clog2(ENTRIES)-1:0]           rd_addr_i,
  output cfc_pkg::cfc_stat_t                   stat_o,
  input  logic                                 in_cmd_i,
  input  logic [cfc_pkg::InDataW-1:0]          in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 out_hit_o,
  output logic [cfc_pkg::OutDataW-1:0]         out_data_o
);

  localparam int unsigned AddrW  = $clog2(ENTRIES);
  localparam int unsigned EntryW = $bits(cfc_pkg::cfc_entry_t);

  // Captured request
  logic                          cmd_q;
  logic [cfc_pkg::IdW-1:0]       id_q;
  logic                          ext_q;
  logic                          rtr_q;
  logic [cfc_pkg::LenW-1:0]      len_q;
  logic                          gen_q;
  logic [cfc_pkg::BytesW-1:0]    data_q;
  logic [cfc_pkg::StampW-1:0]    now_q;

  logic [ENTRIES-1:0]            valid_q;
  logic                          cmp_en_q;
  logic [AddrW-1:0]              cmp_idx_q;

  logic                          match_found_q, free_found_q, old_found_q;
  logic [AddrW-1:0]              match_idx_q, free_idx_q, old_idx_q;
  cfc_pkg::cfc_entry_t           match_ent_q;
  logic [cfc_pkg::StampW-1:0]    old_stamp_q;
  logic [cfc_pkg::BytesW-1:0]    old_bytes_q;

  cfc_pkg::cfc_entry_t           rd_ent;
  logic [EntryW-1:0]             rd_raw;
  logic                          rd_valid;
  logic                          key_hit;

  logic [AddrW-1:0]              wr_idx;
  logic [cfc_pkg::BytesW-1:0]    base_bytes;
  logic [cfc_pkg::BytesW-1:0]    wr_mask;
  cfc_pkg::cfc_entry_t           wr_ent;

  logic                          out_valid_q;
  logic                          out_hit_q;
  logic [cfc_pkg::OutDataW-1:0]  out_data_q;
  logic [cfc_pkg::OutDataW-1:0]  out_data_d;

  cfc_ram #(
    .WIDTH (EntryW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i (wr_idx),
    .wdata_i (wr_ent),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_raw)
  );

  assign rd_ent   = cfc_pkg::cfc_entry_t'(rd_raw);
  assign rd_valid = valid_q[cmp_idx_q];
  assign key_hit  = rd_valid && (rd_ent.id == id_q)
                    && ((cmd_q == cfc_pkg::CMD_LOOKUP) || (rd_ent.ext == ext_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= in_cmd_i;
      id_q   <= in_data_i[28:0];
      ext_q  <= in_data_i[29];
      rtr_q  <= in_data_i[30];
      len_q  <= in_data_i[34:31];
      gen_q  <= in_data_i[35];
      data_q <= in_data_i[99:36];
      now_q  <= in_data_i[131:100];
    end
    cmp_idx_q <= rd_addr_i;
    if (cmp_en_q) begin
      if (key_hit && !match_found_q) begin
        match_idx_q <= cmp_idx_q;
        match_ent_q <= rd_ent;
      end
      if (!rd_valid && !free_found_q) begin
        free_idx_q <= cmp_idx_q;
      end
      // Strict compare keeps the lowest index among equal stamps.
      if (rd_valid && (!old_found_q || rd_ent.stamp < old_stamp_q)) begin
        old_idx_q   <= cmp_idx_q;
        old_stamp_q <= rd_ent.stamp;
        old_bytes_q <= rd_ent.bytes;
      end
    end
    if (cmd_i.emit) begin
      out_hit_q  <= match_found_q;
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      cmp_en_q      <= 1'b0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      old_found_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      cmp_en_q <= cmd_i.rd_en;
      if (cmd_i.load) begin
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
        old_found_q   <= 1'b0;
      end else if (cmp_en_q) begin
        if (key_hit) begin
          match_found_q <= 1'b1;
        end
        if (!rd_valid) begin
          free_found_q <= 1'b1;
        end
        if (rd_valid) begin
          old_found_q <= 1'b1;
        end
      end
      if (cmd_i.write) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pick the slot: same key, else first empty, else oldest.
  always_comb begin
    if (match_found_q) begin
      wr_idx     = match_idx_q;
      base_bytes = match_ent_q.bytes;
    end else if (free_found_q) begin
      wr_idx     = free_idx_q;
      base_bytes = '0;
    end else begin
      wr_idx     = old_idx_q;
      base_bytes = old_bytes_q;
    end
    wr_mask      = cfc_pkg::byte_mask(len_q);
    wr_ent.stamp = now_q;
    wr_ent.bytes = (base_bytes & ~wr_mask) | (data_q & wr_mask);
    wr_ent.gen   = gen_q;
    wr_ent.len   = len_q;
    wr_ent.rtr   = rtr_q;
    wr_ent.ext   = ext_q;
    wr_ent.id    = id_q;
  end

  always_comb begin
    out_data_d = '0;
    if (match_found_q) begin
      out_data_d[28:0]   = match_ent_q.id;
      out_data_d[29]     = match_ent_q.ext;
      out_data_d[33:30]  = match_ent_q.len;
      out_data_d[34]     = match_ent_q.gen;
      out_data_d[98:35]  = match_ent_q.bytes & cfc_pkg::byte_mask(match_ent_q.len);
      out_data_d[130:99] = now_q - match_ent_q.stamp;
    end else begin
      out_data_d[28:0]   = id_q;
    end
  end

  assign stat_o.is_store = (cmd_q == cfc_pkg::CMD_STORE);
  assign stat_o.out_full = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_hit_o   = out_hit_q;
  assign out_data_o  = out_data_q;

endmodule

[src/can_frame_last_value_cache_top.sv]
// Channel   Dir  Beat contents
// s_axis    in   tuser: cmd; tdata: can_id, extended, remote, length_code,
//                generated_flag, payload, now_ms (zero pad to 136)
// m_axis    out  tuser: hit; tdata: hit_id, hit_extended, hit_length,
//                hit_generated, hit_payload, age_ms (zero pad to 136)
//
// Each beat is accepted, then the full table is scanned with one RAM read per slot
// from the single-read-port slot RAM, the last read is compared, and the slot is
// written or the result register loaded; only then is a new beat accepted.
// Reset clears all slot valid bits at once; no clearing pass is needed.
// A store gives no result beat. A held result stalls only a lookup at its end.
module can_frame_last_value_cache_top #(
  parameter int unsigned ENTRIES = 96
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [28:0] can_id, [29] extended, [30] remote, [34:31] length_code,
  // [35] generated_flag, [99:36] payload, [131:100] now_ms
  input  logic [cfc_pkg::InDataW-1:0]     s_axis_tdata,
  // [0] cmd
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [28:0] hit_id, [29] hit_extended, [33:30] hit_length, [34] hit_generated,
  // [98:35] hit_payload, [130:99] age_ms
  output logic [cfc_pkg::OutDataW-1:0]    m_axis_tdata,
  // [0] hit
  output logic                            m_axis_tuser
);

  cfc_pkg::cfc_cmd_t          cmd;
  cfc_pkg::cfc_stat_t         stat;
  logic [$clog2(ENTRIES)-1:0] rd_addr;

  cfc_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  cfc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .stat_o      (stat),
    .in_cmd_i    (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_hit_o   (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.emit))
    else $error("result beat appeared without an emit command");

  a_no_scan_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !cmd.rd_en && !cmd.write && !cmd.emit)
    else $error("datapath command active while accepting");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result register overwritten while held");
`endif

endmodule

[bench/tb_can_frame_last_value_cache_top.sv]
`timescale 1ns / 100ps

module tb_can_frame_last_value_cache_top;

  localparam int unsigned IdW        = cfc_pkg::IdW;
  localparam int unsigned LenW       = cfc_pkg::LenW;
  localparam int unsigned BytesW     = cfc_pkg::BytesW;
  localparam int unsigned StampW     = cfc_pkg::StampW;
  localparam int unsigned InDataW    = cfc_pkg::InDataW;
  localparam int unsigned OutDataW   = cfc_pkg::OutDataW;
  localparam logic        CMD_STORE  = cfc_pkg::CMD_STORE;
  localparam logic        CMD_LOOKUP = cfc_pkg::CMD_LOOKUP;

  localparam int unsigned ENTRIES     = 96;
  localparam int unsigned HOLD_AT     = 420;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned CALM_TAIL   = 80;
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned DRAIN       = 4 * (ENTRIES + 3);

  typedef struct packed {
    logic              cmd;
    logic [IdW-1:0]    id;
    logic              ext;
    logic              rtr;
    logic [LenW-1:0]   len;
    logic              gen;
    logic [BytesW-1:0] data;
    logic [StampW-1:0] now;
  } frame_req_t;

  typedef struct packed {
    logic              hit;
    logic [IdW-1:0]    id;
    logic              ext;
    logic [LenW-1:0]   len;
    logic              gen;
    logic [BytesW-1:0] data;
    logic [StampW-1:0] age;
  } lookup_res_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  can_frame_last_value_cache_top #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the frame table
  bit                c_valid [ENTRIES];
  logic [IdW-1:0]    c_id    [ENTRIES];
  logic              c_ext   [ENTRIES];
  logic              c_rtr   [ENTRIES];
  logic [LenW-1:0]   c_len   [ENTRIES];
  logic              c_gen   [ENTRIES];
  logic [BytesW-1:0] c_bytes [ENTRIES];
  logic [StampW-1:0] c_stamp [ENTRIES];

  frame_req_t  pending_q[$];
  lookup_res_t lookup_q[$];
  logic [IdW-1:0] id_pool[$];
  logic [StampW-1:0] clock_ms = '0;

  frame_req_t  cur_req;
  int unsigned n_accepted   = 0;
  int unsigned send_gap     = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  int unsigned n_bad        = 0;
  int unsigned quiet_cycles = 0;

  function automatic logic [BytesW-1:0] keep_mask(input logic [LenW-1:0] len);
    if (len >= 4'd8) return '1;
    return (64'd1 << (8 * len)) - 64'd1;
  endfunction

  // Apply one beat to the shadow table; return 1 when a result beat follows.
  function automatic bit cache_apply(input frame_req_t rq, output lookup_res_t rs);
    int slot;
    logic [BytesW-1:0] m;
    rs = '0;
    if (rq.cmd == CMD_STORE) begin
      slot = -1;
      for (int k = 0; k < ENTRIES; k++)
        if (slot < 0 && c_valid[k] && c_id[k] == rq.id && c_ext[k] == rq.ext) slot = k;
      for (int k = 0; k < ENTRIES; k++)
        if (slot < 0 && !c_valid[k]) slot = k;
      if (slot < 0) begin
        slot = 0;
        for (int k = 1; k < ENTRIES; k++)
          if (c_stamp[k] < c_stamp[slot]) slot = k;
      end
      m = keep_mask(rq.len);
      c_valid[slot] = 1'b1;
      c_id[slot]    = rq.id;
      c_ext[slot]   = rq.ext;
      c_rtr[slot]   = rq.rtr;
      c_len[slot]   = rq.len;
      c_gen[slot]   = rq.gen;
      c_stamp[slot] = rq.now;
      c_bytes[slot] = (c_bytes[slot] & ~m) | (rq.data & m);
      return 1'b0;
    end
    rs.id = rq.id;
    for (int k = 0; k < ENTRIES; k++) begin
      if (c_valid[k] && c_id[k] == rq.id) begin
        rs.hit  = 1'b1;
        rs.ext  = c_ext[k];
        rs.len  = c_len[k];
        rs.gen  = c_gen[k];
        rs.data = c_bytes[k] & keep_mask(c_len[k]);
        rs.age  = rq.now - c_stamp[k];
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  task automatic push_frame(input logic cmd, input logic [IdW-1:0] id, input logic ext,
                            input logic rtr, input logic [LenW-1:0] len, input logic gen,
                            input logic [BytesW-1:0] data, input logic [StampW-1:0] now);
    frame_req_t rq;
    rq.cmd  = cmd;
    rq.id   = id;
    rq.ext  = ext;
    rq.rtr  = rtr;
    rq.len  = len;
    rq.gen  = gen;
    rq.data = data;
    rq.now  = now;
    pending_q.push_back(rq);
  endtask

  // Mostly small forward steps, some repeats for stamp ties, rare jumps anywhere.
  function automatic logic [StampW-1:0] next_stamp();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) clock_ms = $urandom;
    else if (r >= 4) clock_ms = clock_ms + $urandom_range(1, 40);
    return clock_ms;
  endfunction

  task automatic push_random(input int unsigned store_pct);
    logic           cmd;
    logic [IdW-1:0] id;
    cmd = ($urandom_range(0, 99) < store_pct) ? CMD_STORE : CMD_LOOKUP;
    id  = id_pool[$urandom_range(0, id_pool.size() - 1)];
    if (cmd == CMD_LOOKUP && $urandom_range(0, 9) == 0) id = IdW'($urandom);
    push_frame(cmd, id, 1'($urandom), 1'($urandom), LenW'($urandom), 1'($urandom),
               {$urandom, $urandom}, next_stamp());
  endtask

  task automatic refill_pool(input int unsigned n);
    id_pool.delete();
    for (int k = 0; k < n; k++) id_pool.push_back(IdW'($urandom));
  endtask

  // Source side: present beats from the pending queue, hold until taken.
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_res_t res;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        n_accepted <= n_accepted + 1;
        if (cache_apply(cur_req, res)) lookup_q.push_back(res);
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > CALM_TAIL && $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(1, 14) - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_req = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_req.cmd;
          s_axis_tdata  <= {4'b0, cur_req.now, cur_req.data, cur_req.gen, cur_req.len,
                            cur_req.rtr, cur_req.ext, cur_req.id};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: random stalls plus one long hold-off to back up the block.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (pending_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest predicted lookup.
  always @(posedge clk_i) begin
    lookup_res_t got;
    lookup_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.hit  = m_axis_tuser;
      got.id   = m_axis_tdata[28:0];
      got.ext  = m_axis_tdata[29];
      got.len  = m_axis_tdata[33:30];
      got.gen  = m_axis_tdata[34];
      got.data = m_axis_tdata[98:35];
      got.age  = m_axis_tdata[130:99];
      if (lookup_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result beat: hit=%0b id=%h ext=%0b len=%0d gen=%0b data=%h age=%h",
                   got.hit, got.id, got.ext, got.len, got.gen, got.data, got.age);
      end else begin
        want = lookup_q.pop_front();
        if (got.hit !== want.hit || got.id !== want.id || got.ext !== want.ext ||
            got.len !== want.len || got.gen !== want.gen || got.data !== want.data ||
            got.age !== want.age) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("lookup mismatch: expected hit=%0b id=%h ext=%0b len=%0d gen=%0b data=%h age=%h",
                     want.hit, want.id, want.ext, want.len, want.gen, want.data, want.age);
            $display("                 actual   hit=%0b id=%h ext=%0b len=%0d gen=%0b data=%h age=%h",
                     got.hit, got.id, got.ext, got.len, got.gen, got.data, got.age);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < ENTRIES; k++) c_bytes[k] = '0;

    // Directed: empty table, zero and full length, same key rewrite, stamp wrap,
    // same id in both formats, extreme ids.
    push_frame(CMD_LOOKUP, '0, 1'b1, 1'b1, '1, 1'b1, '1, 32'd7);
    push_frame(CMD_STORE, '0, 1'b0, 1'b1, 4'd0, 1'b1, '1, 32'd0);
    push_frame(CMD_LOOKUP, '0, 1'b0, 1'b0, 4'd0, 1'b0, '0, 32'd3);
    push_frame(CMD_STORE, '0, 1'b0, 1'b0, 4'd15, 1'b0, '1, 32'd5);
    push_frame(CMD_LOOKUP, '0, 1'b0, 1'b0, 4'd0, 1'b0, '0, 32'hFFFF_FFFF);
    push_frame(CMD_STORE, '0, 1'b0, 1'b0, 4'd3, 1'b1, '0, 32'd10);
    push_frame(CMD_LOOKUP, '0, 1'b0, 1'b0, 4'd0, 1'b0, '0, 32'd10);
    push_frame(CMD_STORE, '0, 1'b0, 1'b1, 4'd8, 1'b0, 64'h0123_4567_89AB_CDEF, 32'd20);
    push_frame(CMD_STORE, '0, 1'b0, 1'b0, 4'd2, 1'b1, 64'h0, 32'd21);
    push_frame(CMD_LOOKUP, '0, 1'b0, 1'b0, 4'd0, 1'b0, '0, 32'd30);
    push_frame(CMD_STORE, '1, 1'b1, 1'b0, 4'd8, 1'b1, 64'hFEDC_BA98_7654_3210, 32'hFFFF_FFFF);
    push_frame(CMD_STORE, '1, 1'b0, 1'b1, 4'd4, 1'b0, '1, 32'h8000_0000);
    push_frame(CMD_LOOKUP, '1, 1'b0, 1'b0, 4'd0, 1'b0, '0, 32'd4);
    push_frame(CMD_LOOKUP, 29'h1FFF_FFFE, 1'b1, 1'b1, '1, 1'b1, '1, '1);
    push_frame(CMD_STORE, 29'h1555_5555, 1'b1, 1'b1, 4'd7, 1'b1, 64'hAAAA_5555_AAAA_5555, '1);
    push_frame(CMD_LOOKUP, 29'h1555_5555, 1'b0, 1'b0, 4'd0, 1'b0, '0, 32'd0);
    push_frame(CMD_STORE, 29'h0AAA_AAAA, 1'b0, 1'b0, 4'd1, 1'b0, 64'h5555_AAAA_5555_AAAA, 32'd1);
    push_frame(CMD_LOOKUP, 29'h0AAA_AAAA, 1'b1, 1'b1, '1, 1'b1, '1, 32'd0);

    // Few ids: heavy rewrite of the same keys, many hits
    refill_pool(12);
    for (int k = 0; k < 300; k++) push_random(55);
    // Many ids: table fills up and oldest slots get replaced
    refill_pool(140);
    for (int k = 0; k < 400; k++) push_random(60);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() > 0 || s_axis_tvalid || lookup_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (n_bad == 0 && lookup_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[can_frame_last_value_cache_top.f]
src/cfc_pkg.sv
src/cfc_ram.sv
src/cfc_ctrl.sv
src/cfc_dp.sv
src/can_frame_last_value_cache_top.sv
bench/tb_can_frame_last_value_cache_top.sv
